// ----- rtl/ipc_pkg.sv -----
// Shared types, constants and controller/datapath command structs for the classifier.
package ipc_pkg;

    // Field widths
    localparam int NUM_W      = 16;
    localparam int MAG_W      = 15;
    localparam int VERDICT_W  = 2;
    localparam int VALUE_W    = 17;
    localparam int MODE_W     = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Trial division datapath widths: divisor reaches 182, its square 33124
    localparam int DIV_W  = 8;
    localparam int REM_W  = DIV_W + 1;
    localparam int SQ_W   = 16;
    localparam int CNT_W  = 4;

    // Decimal digit datapath: quotient of a 15-bit value by ten fits 12 bits
    localparam int Q_W        = 12;
    localparam int DIG_W      = 4;
    localparam int RECIP_W    = 16;
    localparam int PROD_W     = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT = 19;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_PARITY     = 3'd1;
    localparam mode_t MODE_PRIME      = 3'd2;
    localparam mode_t MODE_PALINDROME = 3'd3;
    localparam mode_t MODE_SIGN       = 3'd4;
    localparam mode_t MODE_REVERSE    = 3'd5;
    localparam mode_t MODE_DIGITSUM   = 3'd6;
    localparam mode_t MODE_RESET      = MODE_PARITY;

    localparam logic [VERDICT_W-1:0] VERDICT_FALSE = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_TRUE  = 2'd1;
    localparam logic [VERDICT_W-1:0] SIGN_POS      = 2'd0;
    localparam logic [VERDICT_W-1:0] SIGN_NEG      = 2'd1;
    localparam logic [VERDICT_W-1:0] SIGN_ZERO     = 2'd2;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_MODE = 1'b1;

    // Register index (word address bit)
    localparam logic REG_MODE_INDEX = 1'b0;

    // Constants of the arithmetic
    localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
    localparam logic [CNT_W-1:0]   DIV_FIRST_BIT = 4'd14;
    localparam logic [DIV_W-1:0]   DIVISOR_INIT  = 8'd2;
    localparam logic [SQ_W-1:0]    SQUARE_INIT   = 16'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME_CHK,
        S_DIV,
        S_DIG_CHK,
        S_DIG_ACC,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;       // capture request, init working registers
        logic div_start;  // clear remainder, point at top bit
        logic div_step;   // one restoring remainder step
        logic prime_adv;  // move to next trial divisor
        logic prime_wr;   // record prime verdict
        logic prime_val;
        logic dig_quot;   // register quotient by ten
        logic dig_acc;    // fold one digit into accumulator
        logic finish;     // load output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic n_le_one;
        logic sq_gt_n;
        logic div_last;
        logic rem_zero_next;
        logic t_zero;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- rtl/ipc_if.sv -----
// Request and result channel interfaces of the classifier.
interface ipc_num_if;
    logic                               valid;
    logic                               ready;
    logic signed [ipc_pkg::NUM_W-1:0]   number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface ipc_res_if;
    logic                               valid;
    logic                               ready;
    logic                               status;
    logic [ipc_pkg::VERDICT_W-1:0]      verdict;
    logic [ipc_pkg::VALUE_W-1:0]        value;

    modport source (output valid, output status, output verdict, output value, input ready);
    modport sink   (input valid, input status, input verdict, input value, output ready);
endinterface

// ----- rtl/ipc_ctrl.sv -----
// Sequencing state machine for the classifier.
module ipc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  ipc_pkg::mode_t      mode,
    input  logic                in_valid,
    output logic                in_ready,
    input  ipc_pkg::ctrl_sts_t  sts,
    output ipc_pkg::ctrl_cmd_t  cmd
);

    ipc_pkg::state_t state_reg;
    ipc_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ipc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (mode) inside
                        ipc_pkg::MODE_PRIME:
                            state_next = ipc_pkg::S_PRIME_CHK;
                        ipc_pkg::MODE_PALINDROME, ipc_pkg::MODE_REVERSE,
                        ipc_pkg::MODE_DIGITSUM:
                            state_next = ipc_pkg::S_DIG_CHK;
                        default:
                            state_next = ipc_pkg::S_FINISH;
                    endcase
                end
            end
            ipc_pkg::S_PRIME_CHK:
            begin
                if (sts.n_le_one)
                begin
                    cmd.prime_wr  = 1'b1;
                    cmd.prime_val = 1'b0;
                    state_next    = ipc_pkg::S_FINISH;
                end
                else if (sts.sq_gt_n)
                begin
                    // no divisor up to the square root: prime
                    cmd.prime_wr  = 1'b1;
                    cmd.prime_val = 1'b1;
                    state_next    = ipc_pkg::S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ipc_pkg::S_DIV;
                end
            end
            ipc_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    if (sts.rem_zero_next)
                    begin
                        cmd.prime_wr  = 1'b1;
                        cmd.prime_val = 1'b0;
                        state_next    = ipc_pkg::S_FINISH;
                    end
                    else
                    begin
                        cmd.prime_adv = 1'b1;
                        state_next    = ipc_pkg::S_PRIME_CHK;
                    end
                end
            end
            ipc_pkg::S_DIG_CHK:
            begin
                if (sts.t_zero)
                begin
                    state_next = ipc_pkg::S_FINISH;
                end
                else
                begin
                    cmd.dig_quot = 1'b1;
                    state_next   = ipc_pkg::S_DIG_ACC;
                end
            end
            ipc_pkg::S_DIG_ACC:
            begin
                cmd.dig_acc = 1'b1;
                state_next  = ipc_pkg::S_DIG_CHK;
            end
            ipc_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ipc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ipc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/ipc_datapath.sv -----
// Working registers, remainder unit, digit unit and output register of the classifier.
module ipc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ipc_pkg::mode_t                      mode,
    input  logic signed [ipc_pkg::NUM_W-1:0]    number,
    input  ipc_pkg::ctrl_cmd_t                  cmd,
    output ipc_pkg::ctrl_sts_t                  sts,
    ipc_res_if.source                           result
);

    logic signed [ipc_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [ipc_pkg::MAG_W-1:0]          t_reg, t_next;
    logic [ipc_pkg::VALUE_W-1:0]        acc_reg, acc_next;
    logic [ipc_pkg::Q_W-1:0]            q_reg, q_next;
    logic [ipc_pkg::DIV_W-1:0]          d_reg, d_next;
    logic [ipc_pkg::SQ_W-1:0]           sq_reg, sq_next;
    logic [ipc_pkg::DIV_W-1:0]          rem_reg, rem_next;
    logic [ipc_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic                               prime_reg, prime_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               out_status_reg, out_status_next;
    logic [ipc_pkg::VERDICT_W-1:0]      out_verdict_reg, out_verdict_next;
    logic [ipc_pkg::VALUE_W-1:0]        out_value_reg, out_value_next;

    logic [ipc_pkg::MAG_W-1:0]          mag;
    logic [ipc_pkg::REM_W-1:0]          rem_shift;
    logic [ipc_pkg::REM_W-1:0]          rem_sub;
    logic [ipc_pkg::DIV_W-1:0]          rem_step;
    logic [ipc_pkg::PROD_W-1:0]         recip_prod;
    logic [ipc_pkg::MAG_W:0]            q_x10;
    logic [ipc_pkg::MAG_W:0]            dig_diff;
    logic [ipc_pkg::DIG_W-1:0]          digit;
    logic [ipc_pkg::VALUE_W+2:0]        acc_x10;
    logic                               is_positive;

    assign mag         = num_reg[ipc_pkg::MAG_W-1:0];
    assign is_positive = !num_reg[ipc_pkg::NUM_W-1] && (num_reg != '0);

    // Restoring remainder: one dividend bit per cycle, MSB first
    assign rem_shift = {rem_reg, mag[cnt_reg]};
    assign rem_sub   = rem_shift - {1'b0, d_reg};
    assign rem_step  = (rem_shift >= {1'b0, d_reg}) ? rem_sub[ipc_pkg::DIV_W-1:0]
                                                    : rem_shift[ipc_pkg::DIV_W-1:0];

    // Divide by ten through the reciprocal, exact for 15-bit values
    assign recip_prod = ipc_pkg::PROD_W'(t_reg) * ipc_pkg::PROD_W'(ipc_pkg::RECIP_TEN);
    assign q_x10      = ({q_reg, 3'b000} + {3'b000, q_reg, 1'b0});
    assign dig_diff   = {1'b0, t_reg} - q_x10;
    assign digit      = dig_diff[ipc_pkg::DIG_W-1:0];
    assign acc_x10    = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0};

    // Status to the controller
    always_comb
    begin
        sts.n_le_one      = (num_reg <= 16'sd1);
        sts.sq_gt_n       = (sq_reg > {1'b0, mag});
        sts.div_last      = (cnt_reg == '0);
        sts.rem_zero_next = (rem_step == '0);
        sts.t_zero        = (t_reg == '0);
        sts.out_free      = !out_valid_reg || result.ready;
    end

    // Working register updates
    always_comb
    begin
        num_next   = num_reg;
        t_next     = t_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        prime_next = prime_reg;

        if (cmd.load)
        begin
            num_next   = number;
            t_next     = (!number[ipc_pkg::NUM_W-1] && (number != '0))
                         ? number[ipc_pkg::MAG_W-1:0] : '0;
            acc_next   = '0;
            d_next     = ipc_pkg::DIVISOR_INIT;
            sq_next    = ipc_pkg::SQUARE_INIT;
            prime_next = 1'b0;
        end
        if (cmd.div_start)
        begin
            rem_next = '0;
            cnt_next = ipc_pkg::DIV_FIRST_BIT;
        end
        if (cmd.div_step)
        begin
            rem_next = rem_step;
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.prime_adv)
        begin
            // (d+1)^2 = d^2 + 2d + 1
            d_next  = d_reg + 1'b1;
            sq_next = sq_reg + ipc_pkg::SQ_W'({d_reg, 1'b1});
        end
        if (cmd.prime_wr)
        begin
            prime_next = cmd.prime_val;
        end
        if (cmd.dig_quot)
        begin
            q_next = recip_prod[ipc_pkg::RECIP_SHIFT +: ipc_pkg::Q_W];
        end
        if (cmd.dig_acc)
        begin
            t_next = ipc_pkg::MAG_W'(q_reg);
            if (mode == ipc_pkg::MODE_DIGITSUM)
            begin
                acc_next = acc_reg + ipc_pkg::VALUE_W'(digit);
            end
            else
            begin
                acc_next = acc_x10[ipc_pkg::VALUE_W-1:0] + ipc_pkg::VALUE_W'(digit);
            end
        end
    end

    // Result formatting and output register
    always_comb
    begin
        out_valid_next   = out_valid_reg && !result.ready;
        out_status_next  = out_status_reg;
        out_verdict_next = out_verdict_reg;
        out_value_next   = out_value_reg;
        if (cmd.finish)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = ipc_pkg::STATUS_OK;
            out_verdict_next = ipc_pkg::VERDICT_FALSE;
            out_value_next   = '0;
            unique case (mode)
                ipc_pkg::MODE_PARITY:
                    out_verdict_next = num_reg[0] ? ipc_pkg::VERDICT_FALSE
                                                  : ipc_pkg::VERDICT_TRUE;
                ipc_pkg::MODE_PRIME:
                    out_verdict_next = prime_reg ? ipc_pkg::VERDICT_TRUE
                                                 : ipc_pkg::VERDICT_FALSE;
                ipc_pkg::MODE_PALINDROME:
                    out_verdict_next = (!num_reg[ipc_pkg::NUM_W-1] &&
                                        (acc_reg == ipc_pkg::VALUE_W'(mag)))
                                       ? ipc_pkg::VERDICT_TRUE : ipc_pkg::VERDICT_FALSE;
                ipc_pkg::MODE_SIGN:
                    out_verdict_next = is_positive ? ipc_pkg::SIGN_POS
                                     : num_reg[ipc_pkg::NUM_W-1] ? ipc_pkg::SIGN_NEG
                                     : ipc_pkg::SIGN_ZERO;
                ipc_pkg::MODE_REVERSE, ipc_pkg::MODE_DIGITSUM:
                    out_value_next = acc_reg;
                default:
                    out_status_next = ipc_pkg::STATUS_BAD_MODE;
            endcase
        end
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        num_reg         <= num_next;
        t_reg           <= t_next;
        acc_reg         <= acc_next;
        q_reg           <= q_next;
        d_reg           <= d_next;
        sq_reg          <= sq_next;
        rem_reg         <= rem_next;
        cnt_reg         <= cnt_next;
        prime_reg       <= prime_next;
        out_status_reg  <= out_status_next;
        out_verdict_reg <= out_verdict_next;
        out_value_reg   <= out_value_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.status  = out_status_reg;
    assign result.verdict = out_verdict_reg;
    assign result.value   = out_value_reg;

    // Remainder stays below the divisor throughout a division
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < d_reg))
        else $error("remainder not below divisor");

    // Square tracker matches the current divisor
    a_square_track: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (ipc_pkg::SQ_W'(d_reg * d_reg) == sq_reg))
        else $error("divisor square out of step");

    // Reciprocal quotient leaves a single decimal digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dig_acc |-> (dig_diff < (ipc_pkg::MAG_W+1)'(10)))
        else $error("digit extraction out of range");

    // A finished request always shows up at the output
    a_finish_visible: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished request not presented");

endmodule

// ----- rtl/integer_property_classifier.sv -----
// Top level of the integer classifier: register port, controller and datapath.
//
// Each request carries one signed 16-bit number; the mode register picks parity, primality,
// decimal palindrome, sign class, digit reversal or digit sum, and every request gives one
// result. One request is worked on at a time and the result waits in an output register, so
// a new request can be taken while the previous result is still pending. Parity, sign and
// invalid modes go from acceptance straight to the finish state. Digit modes pass a check
// state and an accumulate state once per decimal digit. Primality tries divisors from d = 2
// upwards while d*d <= n; each trial runs the one-bit-per-cycle remainder unit over the 15
// magnitude bits, then a check; a composite stops at its smallest factor. The mode register
// sits at byte address 0, to be written only while idle; the block does not enforce this.
module integer_property_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ipc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ipc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ipc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    ipc_num_if.sink                             request,
    ipc_res_if.source                           result
);

    ipc_pkg::mode_t      mode_reg, mode_next;
    ipc_pkg::ctrl_cmd_t  cmd;
    ipc_pkg::ctrl_sts_t  sts;
    logic                cfg_write;
    logic                hit_mode;

    // Register port decode
    assign pready    = 1'b1;
    assign hit_mode  = (paddr[ipc_pkg::APB_ADDR_W-1] == ipc_pkg::REG_MODE_INDEX);
    assign cfg_write = psel && penable && pwrite && pready;
    assign mode_next = (cfg_write && hit_mode) ? pwdata[ipc_pkg::MODE_W-1:0] : mode_reg;
    assign prdata    = hit_mode ? ipc_pkg::APB_DATA_W'(mode_reg) : '0;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ipc_pkg::MODE_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    ipc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .mode   (mode_reg),
        .number (request.number),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule
